// File: rtl/core/s2e_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// s2e_pkg
// Shared widths, constants and sideband types of the symmetric 2x2 eigen
// solver.
// ----------------------------------------------------------------------------
package s2e_pkg;

  localparam int unsigned DW      = 32;           // Q16.16 word width
  localparam int unsigned TINY_W  = 16;           // tiny limit register width
  localparam int unsigned WIDE_W  = DW + 3;       // differences against w1
  localparam int unsigned NORM_W  = 31;           // normalised vector magnitude
  localparam int unsigned VFRAC   = 30;           // Q2.30 fraction bits
  localparam int unsigned POS_W   = 6;            // leading-one position

  localparam logic [DW-1:0] Q30_ONE = 32'h4000_0000;
  localparam logic [DW-1:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [DW-1:0] SAT_MIN = 32'h8000_0000;

  // matrix entries and trace, carried alongside the first square root
  typedef struct packed {
    logic [DW-1:0] a;
    logic [DW-1:0] b;
    logic [DW-1:0] c;
    logic [DW:0]   s;
  } mat_t;

  // finished eigenvalues and saturation flag
  typedef struct packed {
    logic [DW-1:0] eig_larger;
    logic [DW-1:0] eig_smaller;
    logic          status;
  } eig_t;

  // normalised vector, carried alongside the second square root
  typedef struct packed {
    logic [NORM_W-1:0] xn;
    logic [NORM_W-1:0] yn;
    logic              sx;
    logic              sy;
    logic              have;
    eig_t              eig;
  } vec_t;

  // signs and flags, carried alongside the dividers
  typedef struct packed {
    logic sx;
    logic sy;
    logic have;
    eig_t eig;
  } sgn_t;

endpackage
`default_nettype wire

// File: rtl/core/s2e_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// s2e_in_if
// Matrix word channel: valid/ready with the three Q16.16 entries.
// ----------------------------------------------------------------------------
interface s2e_in_if import s2e_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] diag_first;
  logic signed [DW-1:0] off_diag;
  logic signed [DW-1:0] diag_second;

  modport source (output valid, output diag_first, output off_diag, output diag_second,
                  input ready);
  modport sink   (input valid, input diag_first, input off_diag, input diag_second,
                  output ready);
endinterface
`default_nettype wire

// File: rtl/core/s2e_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// s2e_out_if
// Result word channel: eigenvalues, eigenvector and status.
// ----------------------------------------------------------------------------
interface s2e_out_if import s2e_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] eig_larger;
  logic signed [DW-1:0] eig_smaller;
  logic signed [DW-1:0] vec_cos;
  logic signed [DW-1:0] vec_sin;
  logic                 status;

  modport source (output valid, output eig_larger, output eig_smaller, output vec_cos,
                  output vec_sin, output status, input ready);
  modport sink   (input valid, input eig_larger, input eig_smaller, input vec_cos,
                  input vec_sin, input status, output ready);
endinterface
`default_nettype wire

// File: rtl/core/sym2x2_eigen_solver.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sym2x2_eigen_solver
// Eigenvalues and the unit eigenvector of the larger one for a stream of
// symmetric 2x2 matrices [a b; b c] in signed Q16.16.
// ----------------------------------------------------------------------------
//
//  channel   dir  word                                        handshake
//  --------  ---  ------------------------------------------  -----------
//  in_i      in   diag_first, off_diag, diag_second (Q16.16)  valid/ready
//  out_o     out  eig_larger, eig_smaller (Q16.16), vec_cos,  valid/ready
//                 vec_sin (Q2.30), status
//  cfg       in   tiny_limit (16 bits)                        cfg_we_i
//
//  One matrix enters per cycle while out_o is not stalled. The pipeline
//  depth is set by the two bit-serial square roots (33 and 32 stages) and
//  the 31-stage divider for the vector.
//  Reset clears every valid bit and the tiny limit; data registers are not
//  reset. A stall on out_o freezes the whole pipeline and drops in_i.ready;
//  with the output register empty the pipeline keeps moving.
//
module sym2x2_eigen_solver import s2e_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [TINY_W-1:0] cfg_wdata_i,
  s2e_in_if.sink            in_i,
  s2e_out_if.source         out_o
);

  localparam int unsigned R1_W  = 2 * DW + 2;   // (a-c)^2 + (2b)^2
  localparam int unsigned RT1_W = DW + 1;       // its root
  localparam int unsigned R2_W  = 2 * NORM_W + 1;
  localparam int unsigned RT2_W = NORM_W + 1;
  localparam int unsigned NUM_W = NORM_W + VFRAC + 1;
  localparam int unsigned QUO_W = VFRAC + 1;
  localparam logic [POS_W-1:0] NORM_TOP = POS_W'(VFRAC);

  // leading-one position of a magnitude
  function automatic logic [POS_W-1:0] lead_pos(input logic [WIDE_W-1:0] v);
    logic [POS_W-1:0] p;
    p = '0;
    for (int i = 0; i < WIDE_W; i++) begin
      if (v[i]) begin
        p = POS_W'(i);
      end
    end
    return p;
  endfunction

  // clamp a 34-bit eigenvalue to the word range
  function automatic logic [DW:0] sat_eig(input logic [DW+1:0] w);
    logic [DW:0] r;
    if (w[DW+1:DW-1] == 3'b000 || w[DW+1:DW-1] == 3'b111) begin
      r = {1'b0, w[DW-1:0]};
    end else begin
      r = {1'b1, (w[DW+1] ? SAT_MIN : SAT_MAX)};
    end
    return r;
  endfunction

  logic              en;
  logic [TINY_W-1:0] tiny_q;

  // the whole pipe advances unless a finished word is held at the output
  assign en         = !out_o.valid || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tiny_q <= '0;
    end else if (cfg_we_i) begin
      tiny_q <= cfg_wdata_i;
    end
  end

  // ---------------- stage 1: |a-c|, 2|b|, trace ----------------
  logic [DW:0]   dif_d;
  logic [DW-1:0] bmag_d;
  logic          p1_vld_q;
  logic [DW:0]   p1_dm_q;
  logic [DW:0]   p1_bm2_q;
  mat_t          p1_mat_q;

  assign dif_d  = {in_i.diag_first[DW-1], in_i.diag_first}
                - {in_i.diag_second[DW-1], in_i.diag_second};
  assign bmag_d = in_i.off_diag[DW-1] ? DW'(0) - in_i.off_diag : in_i.off_diag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
    end else if (en) begin
      p1_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_dm_q    <= dif_d[DW] ? (DW+1)'(0) - dif_d : dif_d;
      p1_bm2_q   <= {bmag_d, 1'b0};
      p1_mat_q.a <= in_i.diag_first;
      p1_mat_q.b <= in_i.off_diag;
      p1_mat_q.c <= in_i.diag_second;
      p1_mat_q.s <= {in_i.diag_first[DW-1], in_i.diag_first}
                  + {in_i.diag_second[DW-1], in_i.diag_second};
    end
  end

  // ---------------- stage 2: squares ----------------
  logic            p2_vld_q;
  logic [R1_W-1:0] p2_sqd_q;
  logic [R1_W-1:0] p2_sqb_q;
  mat_t            p2_mat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_vld_q <= 1'b0;
    end else if (en) begin
      p2_vld_q <= p1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p2_sqd_q <= R1_W'(p1_dm_q) * R1_W'(p1_dm_q);
      p2_sqb_q <= R1_W'(p1_bm2_q) * R1_W'(p1_bm2_q);
      p2_mat_q <= p1_mat_q;
    end
  end

  // ---------------- stage 3: radicand ----------------
  logic            p3_vld_q;
  logic [R1_W-1:0] p3_rad_q;
  mat_t            p3_mat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p3_vld_q <= 1'b0;
    end else if (en) begin
      p3_vld_q <= p2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p3_rad_q <= p2_sqd_q + p2_sqb_q;
      p3_mat_q <= p2_mat_q;
    end
  end

  // ---------------- discriminant root ----------------
  logic             r1_vld;
  logic [RT1_W-1:0] r1_root;
  logic [$bits(mat_t)-1:0] r1_side;
  mat_t             r1_mat;

  s2e_isqrt_pipe #(
    .RAD_W  (R1_W),
    .ROOT_W (RT1_W),
    .SIDE_W ($bits(mat_t))
  ) u_root_disc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (p3_vld_q),
    .rad_i  (p3_rad_q),
    .side_i (p3_mat_q),
    .vld_o  (r1_vld),
    .root_o (r1_root),
    .side_o (r1_side)
  );

  assign r1_mat = mat_t'(r1_side);

  // ---------------- stage W: eigenvalues and saturation ----------------
  logic [WIDE_W-1:0] sum_hi_d;
  logic [WIDE_W-1:0] sum_lo_d;
  logic [DW:0]       sat_hi_d;
  logic [DW:0]       sat_lo_d;
  logic              pw_vld_q;
  logic [DW+1:0]     pw_w1_q;
  logic [DW-1:0]     pw_a_q;
  logic [DW-1:0]     pw_b_q;
  logic [DW-1:0]     pw_c_q;
  eig_t              pw_eig_q;

  assign sum_hi_d = {{2{r1_mat.s[DW]}}, r1_mat.s} + {2'b00, r1_root};
  assign sum_lo_d = {{2{r1_mat.s[DW]}}, r1_mat.s} - {2'b00, r1_root};
  assign sat_hi_d = sat_eig(sum_hi_d[WIDE_W-1:1]);
  assign sat_lo_d = sat_eig(sum_lo_d[WIDE_W-1:1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pw_vld_q <= 1'b0;
    end else if (en) begin
      pw_vld_q <= r1_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pw_w1_q              <= sum_hi_d[WIDE_W-1:1];
      pw_a_q               <= r1_mat.a;
      pw_b_q               <= r1_mat.b;
      pw_c_q               <= r1_mat.c;
      pw_eig_q.eig_larger  <= sat_hi_d[DW-1:0];
      pw_eig_q.eig_smaller <= sat_lo_d[DW-1:0];
      pw_eig_q.status      <= sat_hi_d[DW] | sat_lo_d[DW];
    end
  end

  // ---------------- stage B1: w1 - a, w1 - c ----------------
  logic              pb_vld_q;
  logic [WIDE_W-1:0] pb_daw_q;
  logic [WIDE_W-1:0] pb_dcw_q;
  logic [DW-1:0]     pb_b_q;
  eig_t              pb_eig_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pb_vld_q <= 1'b0;
    end else if (en) begin
      pb_vld_q <= pw_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pb_daw_q <= {pw_w1_q[DW+1], pw_w1_q} - {{3{pw_a_q[DW-1]}}, pw_a_q};
      pb_dcw_q <= {pw_w1_q[DW+1], pw_w1_q} - {{3{pw_c_q[DW-1]}}, pw_c_q};
      pb_b_q   <= pw_b_q;
      pb_eig_q <= pw_eig_q;
    end
  end

  // ---------------- stage B2: branch tests and vector pick ----------------
  logic [WIDE_W-1:0] tpos_d;
  logic [WIDE_W-1:0] tneg_d;
  logic [WIDE_W-1:0] bx_d;
  logic              big_aw_d;
  logic              big_b_d;
  logic              pv_vld_q;
  logic [WIDE_W-1:0] pv_x_q;
  logic [WIDE_W-1:0] pv_y_q;
  logic              pv_have_q;
  eig_t              pv_eig_q;

  assign tpos_d   = WIDE_W'(tiny_q);
  assign tneg_d   = WIDE_W'(0) - tpos_d;
  assign bx_d     = {{3{pb_b_q[DW-1]}}, pb_b_q};
  // |v| > t as two signed compares side by side
  assign big_aw_d = ($signed(pb_daw_q) > $signed(tpos_d)) ||
                    ($signed(pb_daw_q) < $signed(tneg_d));
  assign big_b_d  = ($signed(bx_d) > $signed(tpos_d)) ||
                    ($signed(bx_d) < $signed(tneg_d));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_vld_q <= 1'b0;
    end else if (en) begin
      pv_vld_q <= pb_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (big_aw_d) begin
        pv_x_q <= bx_d;
        pv_y_q <= pb_daw_q;
      end else if (big_b_d) begin
        pv_x_q <= pb_dcw_q;
        pv_y_q <= bx_d;
      end else begin
        pv_x_q <= '0;
        pv_y_q <= '0;
      end
      pv_have_q <= big_aw_d | big_b_d;
      pv_eig_q  <= pb_eig_q;
    end
  end

  // ---------------- stage M: magnitudes ----------------
  logic              pm_vld_q;
  logic [WIDE_W-1:0] pm_xm_q;
  logic [WIDE_W-1:0] pm_ym_q;
  logic              pm_sx_q;
  logic              pm_sy_q;
  logic              pm_have_q;
  eig_t              pm_eig_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pm_vld_q <= 1'b0;
    end else if (en) begin
      pm_vld_q <= pv_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pm_xm_q   <= pv_x_q[WIDE_W-1] ? WIDE_W'(0) - pv_x_q : pv_x_q;
      pm_ym_q   <= pv_y_q[WIDE_W-1] ? WIDE_W'(0) - pv_y_q : pv_y_q;
      pm_sx_q   <= pv_x_q[WIDE_W-1];
      pm_sy_q   <= pv_y_q[WIDE_W-1];
      pm_have_q <= pv_have_q;
      pm_eig_q  <= pv_eig_q;
    end
  end

  // ---------------- stage L: leading one of the larger magnitude ----------------
  // the OR of both magnitudes has the same leading one as their maximum
  logic              pl_vld_q;
  logic [POS_W-1:0]  pl_pos_q;
  logic [WIDE_W-1:0] pl_xm_q;
  logic [WIDE_W-1:0] pl_ym_q;
  logic              pl_sx_q;
  logic              pl_sy_q;
  logic              pl_have_q;
  eig_t              pl_eig_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pl_vld_q <= 1'b0;
    end else if (en) begin
      pl_vld_q <= pm_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pl_pos_q  <= lead_pos(pm_xm_q | pm_ym_q);
      pl_xm_q   <= pm_xm_q;
      pl_ym_q   <= pm_ym_q;
      pl_sx_q   <= pm_sx_q;
      pl_sy_q   <= pm_sy_q;
      pl_have_q <= pm_have_q;
      pl_eig_q  <= pm_eig_q;
    end
  end

  // ---------------- stage S: normalise into [2^30, 2^31) ----------------
  logic [WIDE_W-1:0] xs_d;
  logic [WIDE_W-1:0] ys_d;
  logic              ps_vld_q;
  logic [NORM_W-1:0] ps_xn_q;
  logic [NORM_W-1:0] ps_yn_q;
  logic              ps_sx_q;
  logic              ps_sy_q;
  logic              ps_have_q;
  eig_t              ps_eig_q;

  always_comb begin
    if (pl_pos_q >= NORM_TOP) begin
      xs_d = pl_xm_q >> (pl_pos_q - NORM_TOP);
      ys_d = pl_ym_q >> (pl_pos_q - NORM_TOP);
    end else begin
      xs_d = pl_xm_q << (NORM_TOP - pl_pos_q);
      ys_d = pl_ym_q << (NORM_TOP - pl_pos_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ps_vld_q <= 1'b0;
    end else if (en) begin
      ps_vld_q <= pl_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ps_xn_q   <= xs_d[NORM_W-1:0];
      ps_yn_q   <= ys_d[NORM_W-1:0];
      ps_sx_q   <= pl_sx_q;
      ps_sy_q   <= pl_sy_q;
      ps_have_q <= pl_have_q;
      ps_eig_q  <= pl_eig_q;
    end
  end

  // ---------------- stage Q: squares of the normalised vector ----------------
  logic                pq_vld_q;
  logic [2*NORM_W-1:0] pq_sqx_q;
  logic [2*NORM_W-1:0] pq_sqy_q;
  vec_t                pq_vec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pq_vld_q <= 1'b0;
    end else if (en) begin
      pq_vld_q <= ps_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pq_sqx_q      <= (2*NORM_W)'(ps_xn_q) * (2*NORM_W)'(ps_xn_q);
      pq_sqy_q      <= (2*NORM_W)'(ps_yn_q) * (2*NORM_W)'(ps_yn_q);
      pq_vec_q.xn   <= ps_xn_q;
      pq_vec_q.yn   <= ps_yn_q;
      pq_vec_q.sx   <= ps_sx_q;
      pq_vec_q.sy   <= ps_sy_q;
      pq_vec_q.have <= ps_have_q;
      pq_vec_q.eig  <= ps_eig_q;
    end
  end

  // ---------------- stage A: norm radicand ----------------
  logic            pa_vld_q;
  logic [R2_W-1:0] pa_rad_q;
  vec_t            pa_vec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pa_vld_q <= 1'b0;
    end else if (en) begin
      pa_vld_q <= pq_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pa_rad_q <= R2_W'(pq_sqx_q) + R2_W'(pq_sqy_q);
      pa_vec_q <= pq_vec_q;
    end
  end

  // ---------------- vector norm root ----------------
  logic             r2_vld;
  logic [RT2_W-1:0] r2_root;
  logic [$bits(vec_t)-1:0] r2_side;
  vec_t             r2_vec;

  s2e_isqrt_pipe #(
    .RAD_W  (R2_W),
    .ROOT_W (RT2_W),
    .SIDE_W ($bits(vec_t))
  ) u_root_norm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (pa_vld_q),
    .rad_i  (pa_rad_q),
    .side_i (pa_vec_q),
    .vld_o  (r2_vld),
    .root_o (r2_root),
    .side_o (r2_side)
  );

  assign r2_vec = vec_t'(r2_side);

  // ---------------- stage N: rounded numerators ----------------
  logic             pn_vld_q;
  logic [NUM_W-1:0] pn_num_x_q;
  logic [NUM_W-1:0] pn_num_y_q;
  logic [RT2_W-1:0] pn_den_q;
  sgn_t             pn_sgn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pn_vld_q <= 1'b0;
    end else if (en) begin
      pn_vld_q <= r2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pn_num_x_q    <= NUM_W'({r2_vec.xn, VFRAC'(0)}) + NUM_W'(r2_root >> 1);
      pn_num_y_q    <= NUM_W'({r2_vec.yn, VFRAC'(0)}) + NUM_W'(r2_root >> 1);
      pn_den_q      <= r2_root;
      pn_sgn_q.sx   <= r2_vec.sx;
      pn_sgn_q.sy   <= r2_vec.sy;
      pn_sgn_q.have <= r2_vec.have;
      pn_sgn_q.eig  <= r2_vec.eig;
    end
  end

  // ---------------- component division ----------------
  // with no vector the divisor is zero; the quotient is ignored below
  logic             dv_vld;
  logic [QUO_W-1:0] dv_qx;
  logic [QUO_W-1:0] dv_qy;
  logic [$bits(sgn_t)-1:0] dv_side;
  sgn_t             dv_sgn;

  s2e_div_pipe #(
    .NUM_W  (NUM_W),
    .DEN_W  (RT2_W),
    .QUO_W  (QUO_W),
    .SIDE_W ($bits(sgn_t))
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (pn_vld_q),
    .num_a_i (pn_num_x_q),
    .num_b_i (pn_num_y_q),
    .den_i   (pn_den_q),
    .side_i  (pn_sgn_q),
    .vld_o   (dv_vld),
    .quo_a_o (dv_qx),
    .quo_b_o (dv_qy),
    .side_o  (dv_side)
  );

  assign dv_sgn = sgn_t'(dv_side);

  // ---------------- output register ----------------
  logic          out_vld_q;
  logic [DW-1:0] cos_d;
  logic [DW-1:0] sin_d;
  logic [DW-1:0] out_cos_q;
  logic [DW-1:0] out_sin_q;
  eig_t          out_eig_q;

  always_comb begin
    if (dv_sgn.have) begin
      cos_d = dv_sgn.sx ? DW'(0) - DW'(dv_qx) : DW'(dv_qx);
      sin_d = dv_sgn.sy ? DW'(0) - DW'(dv_qy) : DW'(dv_qy);
    end else begin
      cos_d = Q30_ONE;
      sin_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_cos_q <= cos_d;
      out_sin_q <= sin_d;
      out_eig_q <= dv_sgn.eig;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.eig_larger  = out_eig_q.eig_larger;
  assign out_o.eig_smaller = out_eig_q.eig_smaller;
  assign out_o.vec_cos     = out_cos_q;
  assign out_o.vec_sin     = out_sin_q;
  assign out_o.status      = out_eig_q.status;

endmodule
`default_nettype wire

// File: rtl/core/s2e_isqrt_pipe.sv
`default_nettype none
// ----------------------------------------------------------------------------
// s2e_isqrt_pipe
// Pipelined floor square root, one root bit per register stage, with a
// sideband word that travels in step.
// ----------------------------------------------------------------------------
module s2e_isqrt_pipe import s2e_pkg::*; #(
  parameter int unsigned RAD_W  = 66,
  parameter int unsigned ROOT_W = 33,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  logic [RAD_W-1:0]  rad_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              vld_o,
  output logic [ROOT_W-1:0] root_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int unsigned TW = ((RAD_W > 2 * ROOT_W) ? RAD_W : 2 * ROOT_W) + 1;

  logic              vld_s  [ROOT_W+1];
  logic [RAD_W-1:0]  rem_s  [ROOT_W+1];
  logic [ROOT_W-1:0] root_s [ROOT_W+1];
  logic [SIDE_W-1:0] side_s [ROOT_W+1];

  assign vld_s[0]  = vld_i;
  assign rem_s[0]  = rad_i;
  assign root_s[0] = '0;
  assign side_s[0] = side_i;

  for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
    localparam int unsigned K = ROOT_W - 1 - j;

    logic [TW-1:0]     trial;
    logic              fits;
    logic              vld_q;
    logic [RAD_W-1:0]  rem_q;
    logic [ROOT_W-1:0] root_q;
    logic [SIDE_W-1:0] side_q;

    // (2*root + 2^K) * 2^K, root bits at and below K still clear
    assign trial = (TW'(root_s[j]) << (K + 1)) + (TW'(1) << (2 * K));
    assign fits  = (trial <= TW'(rem_s[j]));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= vld_s[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (fits) begin
          rem_q  <= rem_s[j] - trial[RAD_W-1:0];
          root_q <= root_s[j] | (ROOT_W'(1) << K);
        end else begin
          rem_q  <= rem_s[j];
          root_q <= root_s[j];
        end
        side_q <= side_s[j];
      end
    end

    assign vld_s[j+1]  = vld_q;
    assign rem_s[j+1]  = rem_q;
    assign root_s[j+1] = root_q;
    assign side_s[j+1] = side_q;
  end

  assign vld_o  = vld_s[ROOT_W];
  assign root_o = root_s[ROOT_W];
  assign side_o = side_s[ROOT_W];

endmodule
`default_nettype wire

// File: rtl/core/s2e_div_pipe.sv
`default_nettype none
// ----------------------------------------------------------------------------
// s2e_div_pipe
// Pipelined restoring divider, two numerators over one denominator, one
// quotient bit per register stage.
// ----------------------------------------------------------------------------
module s2e_div_pipe import s2e_pkg::*; #(
  parameter int unsigned NUM_W  = 62,
  parameter int unsigned DEN_W  = 32,
  parameter int unsigned QUO_W  = 31,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  logic [NUM_W-1:0]  num_a_i,
  input  logic [NUM_W-1:0]  num_b_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              vld_o,
  output logic [QUO_W-1:0]  quo_a_o,
  output logic [QUO_W-1:0]  quo_b_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int unsigned TW = ((NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W) + 1;

  logic              vld_s  [QUO_W+1];
  logic [NUM_W-1:0]  rem_a_s[QUO_W+1];
  logic [NUM_W-1:0]  rem_b_s[QUO_W+1];
  logic [QUO_W-1:0]  quo_a_s[QUO_W+1];
  logic [QUO_W-1:0]  quo_b_s[QUO_W+1];
  logic [DEN_W-1:0]  den_s  [QUO_W+1];
  logic [SIDE_W-1:0] side_s [QUO_W+1];

  assign vld_s[0]   = vld_i;
  assign rem_a_s[0] = num_a_i;
  assign rem_b_s[0] = num_b_i;
  assign quo_a_s[0] = '0;
  assign quo_b_s[0] = '0;
  assign den_s[0]   = den_i;
  assign side_s[0]  = side_i;

  for (genvar j = 0; j < QUO_W; j++) begin : g_stage
    localparam int unsigned K = QUO_W - 1 - j;

    logic [TW-1:0]     trial;
    logic              fit_a;
    logic              fit_b;
    logic              vld_q;
    logic [NUM_W-1:0]  rem_a_q;
    logic [NUM_W-1:0]  rem_b_q;
    logic [QUO_W-1:0]  quo_a_q;
    logic [QUO_W-1:0]  quo_b_q;
    logic [DEN_W-1:0]  den_q;
    logic [SIDE_W-1:0] side_q;

    assign trial = TW'(den_s[j]) << K;
    assign fit_a = (trial <= TW'(rem_a_s[j]));
    assign fit_b = (trial <= TW'(rem_b_s[j]));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= vld_s[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_a_q <= fit_a ? rem_a_s[j] - trial[NUM_W-1:0] : rem_a_s[j];
        rem_b_q <= fit_b ? rem_b_s[j] - trial[NUM_W-1:0] : rem_b_s[j];
        quo_a_q <= fit_a ? quo_a_s[j] | (QUO_W'(1) << K) : quo_a_s[j];
        quo_b_q <= fit_b ? quo_b_s[j] | (QUO_W'(1) << K) : quo_b_s[j];
        den_q   <= den_s[j];
        side_q  <= side_s[j];
      end
    end

    assign vld_s[j+1]   = vld_q;
    assign rem_a_s[j+1] = rem_a_q;
    assign rem_b_s[j+1] = rem_b_q;
    assign quo_a_s[j+1] = quo_a_q;
    assign quo_b_s[j+1] = quo_b_q;
    assign den_s[j+1]   = den_q;
    assign side_s[j+1]  = side_q;
  end

  assign vld_o   = vld_s[QUO_W];
  assign quo_a_o = quo_a_s[QUO_W];
  assign quo_b_o = quo_b_s[QUO_W];
  assign side_o  = side_s[QUO_W];

endmodule
`default_nettype wire

// File: sim/sym2x2_eigen_solver_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sym2x2_eigen_solver_tb
// Streams symmetric 2x2 matrices through the solver and checks every result
// word against an eigen predictor kept in the bench, under varied flow control.
// ----------------------------------------------------------------------------
module sym2x2_eigen_solver_tb;
  import s2e_pkg::*;

  // one expected result word
  typedef struct {
    logic [31:0] larger;
    logic [31:0] smaller;
    logic [31:0] cosv;
    logic [31:0] sinv;
    logic        sat;
  } eigen_word_t;

  localparam int unsigned LATENCY = 109;
  localparam int unsigned STALL_LIMIT = 20000;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [TINY_W-1:0] cfg_wdata_i;

  s2e_in_if  mat_ch ();
  s2e_out_if res_ch ();

  sym2x2_eigen_solver dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (mat_ch.sink),
    .out_o       (res_ch.source)
  );

  // bench copy of the register
  logic [15:0] tiny_copy;
  eigen_word_t expected_words[$];
  int unsigned errors;
  int unsigned words_seen;
  int unsigned idle_cycles;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          timed_out;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // floor square root of a value below 2^72
  function automatic logic [35:0] isqrt(input logic [71:0] v);
    logic [35:0] r;
    logic [35:0] cand;
    r = '0;
    for (int k = 35; k >= 0; k--) begin
      cand = r | (36'd1 << k);
      if ({36'd0, cand} * {36'd0, cand} <= v) r = cand;
    end
    return r;
  endfunction

  function automatic logic [31:0] clamp_eig(input logic signed [63:0] x, inout logic flag);
    if (x > 64'sh7FFF_FFFF) begin
      flag = 1'b1;
      return SAT_MAX;
    end
    if (x < -64'sh8000_0000) begin
      flag = 1'b1;
      return SAT_MIN;
    end
    return x[31:0];
  endfunction

  function automatic logic [63:0] absval(input logic signed [63:0] x);
    return x < 0 ? -x : x;
  endfunction

  // eigenvalues and unit eigenvector of the larger one
  function automatic eigen_word_t solve_eigen(input logic signed [31:0] a,
                                               input logic signed [31:0] b,
                                               input logic signed [31:0] c);
    eigen_word_t w;
    logic signed [63:0] a64, b64, c64, s, w1, w2, x, y;
    logic [63:0] dm, bm2, xm, ym, mx, n;
    logic [71:0] rad;
    logic found;
    a64 = a; b64 = b; c64 = c;
    dm  = absval(a64 - c64);
    bm2 = absval(b64) * 2;
    rad = {8'd0, dm} * {8'd0, dm} + {8'd0, bm2} * {8'd0, bm2};
    n   = {28'd0, isqrt(rad)};
    s   = a64 + c64;
    w1  = (s + $signed(n)) >>> 1;
    w2  = (s - $signed(n)) >>> 1;
    w.sat = 1'b0;
    w.larger  = clamp_eig(w1, w.sat);
    w.smaller = clamp_eig(w2, w.sat);
    found = 1'b1;
    x = 0; y = 0;
    if (absval(a64 - w1) > tiny_copy) begin
      x = b64; y = w1 - a64;
    end else if (absval(b64) > tiny_copy) begin
      x = w1 - c64; y = b64;
    end else begin
      found = 1'b0;
    end
    w.cosv = Q30_ONE;
    w.sinv = '0;
    if (found) begin
      xm = absval(x); ym = absval(y);
      mx = xm > ym ? xm : ym;
      while (mx >= 64'h8000_0000) begin
        xm >>= 1; ym >>= 1; mx >>= 1;
      end
      while (mx != 0 && mx < 64'h4000_0000) begin
        xm <<= 1; ym <<= 1; mx <<= 1;
      end
      n = {28'd0, isqrt({8'd0, xm * xm + ym * ym})};
      if (n != 0) begin
        xm = ((xm << 30) + n / 2) / n;
        ym = ((ym << 30) + n / 2) / n;
        w.cosv = x < 0 ? -xm[31:0] : xm[31:0];
        w.sinv = y < 0 ? -ym[31:0] : ym[31:0];
      end
    end
    return w;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    $display("mismatch on word %0d: %s got %h want %h", words_seen, field, got, want);
  endtask

  // hold valid until the word is taken, idling at random first
  task automatic send_matrix(input logic [31:0] a, input logic [31:0] b,
                             input logic [31:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      mat_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    mat_ch.valid       <= 1'b1;
    mat_ch.diag_first  <= a;
    mat_ch.off_diag    <= b;
    mat_ch.diag_second <= c;
    @(posedge clk_i);
    while (!mat_ch.ready) @(posedge clk_i);
    expected_words.push_back(solve_eigen(a, b, c));
  endtask

  // receiver side: random back-pressure and the checks
  always @(posedge clk_i) begin
    eigen_word_t w;
    if (rst_ni) begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_words.size() == 0) begin
          errors++;
          $display("unexpected result word %0d", words_seen);
        end else begin
          w = expected_words.pop_front();
          if (res_ch.eig_larger !== w.larger)
            report_mismatch("eig_larger", res_ch.eig_larger, w.larger);
          if (res_ch.eig_smaller !== w.smaller)
            report_mismatch("eig_smaller", res_ch.eig_smaller, w.smaller);
          if (res_ch.vec_cos !== w.cosv) report_mismatch("vec_cos", res_ch.vec_cos, w.cosv);
          if (res_ch.vec_sin !== w.sinv) report_mismatch("vec_sin", res_ch.vec_sin, w.sinv);
          if (res_ch.status !== w.sat)
            report_mismatch("status", {31'd0, res_ch.status}, {31'd0, w.sat});
        end
        words_seen++;
      end
      res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog: count cycles with no word moving on either side
  always @(posedge clk_i) begin
    if ((mat_ch.valid && mat_ch.ready) || (res_ch.valid && res_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) timed_out = 1'b1;
  end

  // drain, then let the pipeline empty before touching the register
  task automatic drain_and_configure(input logic [15:0] limit);
    mat_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= limit;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    tiny_copy = limit;
  endtask

  function automatic logic [31:0] rand_entry();
    case ($urandom_range(5))
      0:       return $urandom;
      1:       return $urandom_range(0, 2) == 0 ? 32'h7FFF_FFFF : 32'h8000_0000;
      2:       return {{16{1'($urandom_range(1))}}, 16'($urandom)};
      3:       return {{24{1'($urandom_range(1))}}, 8'($urandom)};
      default: return {{12{1'($urandom_range(1))}}, 20'($urandom)};
    endcase
  endfunction

  // extremes, diagonal and scalar matrices, tiny off-diagonals
  task automatic test_directed();
    send_matrix(32'h0, 32'h0, 32'h0);
    send_matrix(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_matrix(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_matrix(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    send_matrix(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_matrix(32'h0001_0000, 32'h0, 32'h0002_0000);
    send_matrix(32'h0002_0000, 32'h0, 32'h0001_0000);
    send_matrix(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    send_matrix(32'h0003_0000, 32'h0000_0001, 32'h0003_0000);
    send_matrix(32'h0000_0005, 32'hFFFF_FFFF, 32'h0000_0005);
    send_matrix(32'hFFFF_0000, 32'h0000_8000, 32'h0001_0000);
    send_matrix(32'h0, 32'hFFFF_FFFF, 32'h0);
    send_matrix(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
    send_matrix(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
  endtask

  task automatic test_random(input int unsigned count);
    for (int unsigned i = 0; i < count; i++)
      send_matrix(rand_entry(), rand_entry(), rand_entry());
  endtask

  initial begin
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_wdata_i       = '0;
    mat_ch.valid      = 1'b0;
    mat_ch.diag_first = '0;
    mat_ch.off_diag   = '0;
    mat_ch.diag_second = '0;
    res_ch.ready      = 1'b0;
    tiny_copy         = '0;
    errors            = 0;
    words_seen        = 0;
    idle_cycles       = 0;
    timed_out         = 1'b0;
    send_idle_pct     = 33;
    recv_idle_pct     = 50;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    drain_and_configure(16'hFFFF);
    test_directed();
    test_random(400);
    send_idle_pct = 50;
    recv_idle_pct = 33;
    drain_and_configure(16'h0100);
    test_random(500);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    drain_and_configure(16'h0000);
    test_random(550);

    mat_ch.valid <= 1'b0;
    while (expected_words.size() != 0 && !timed_out) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    $display("covered %0d result words over tiny limits 0, 0x0100 and 0xFFFF", words_seen);
    $display("flow control: sender and receiver stalls swapped, then free running");
    if (errors == 0 && !timed_out && expected_words.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // abort on a hung pipeline
  initial begin
    wait (timed_out);
    $display("watchdog expired with %0d words pending", expected_words.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
